// File: rtl/script_token_scanner_defines.svh
// Assertion macros shared by the script token scanner RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef SCRIPT_TOKEN_SCANNER_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define STS_ASSERT_AT_CLOCK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define STS_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// File: rtl/sts_pkg.sv
// Package for the script token scanner: token kinds, error codes, scan modes,
// keyword table and character classification functions. Depends on nothing.
package sts_pkg;

   localparam int KEYWORD_CHARS = 8;
   localparam int MAX_TOKENS = 4;
   localparam int NUM_KEYWORDS = 24;

   localparam logic [6:0] KIND_END = 7'd0;
   localparam logic [6:0] KIND_ERROR = 7'd1;
   localparam logic [6:0] KIND_IDENT = 7'd2;
   localparam logic [6:0] KIND_NUMBER = 7'd3;
   localparam logic [6:0] KIND_STRING = 7'd4;
   localparam logic [6:0] KIND_KW_FIRST = 7'd5;
   localparam logic [6:0] KIND_KW_AND = 7'd5;
   localparam logic [6:0] KIND_KW_OR = 7'd20;
   localparam logic [6:0] KIND_LPAREN = 7'd29;
   localparam logic [6:0] KIND_RPAREN = 7'd30;
   localparam logic [6:0] KIND_LBRACE = 7'd31;
   localparam logic [6:0] KIND_RBRACE = 7'd32;
   localparam logic [6:0] KIND_LBRACKET = 7'd33;
   localparam logic [6:0] KIND_RBRACKET = 7'd34;
   localparam logic [6:0] KIND_COLON = 7'd35;
   localparam logic [6:0] KIND_SEMICOLON = 7'd36;
   localparam logic [6:0] KIND_COMMA = 7'd37;
   localparam logic [6:0] KIND_DOT = 7'd38;
   localparam logic [6:0] KIND_MINUS = 7'd39;
   localparam logic [6:0] KIND_MINUS_EQ = 7'd40;
   localparam logic [6:0] KIND_DEC = 7'd41;
   localparam logic [6:0] KIND_PLUS = 7'd42;
   localparam logic [6:0] KIND_PLUS_EQ = 7'd43;
   localparam logic [6:0] KIND_INC = 7'd44;
   localparam logic [6:0] KIND_SLASH = 7'd45;
   localparam logic [6:0] KIND_SLASH_EQ = 7'd46;
   localparam logic [6:0] KIND_STAR = 7'd47;
   localparam logic [6:0] KIND_STAR_EQ = 7'd48;
   localparam logic [6:0] KIND_BANG = 7'd49;
   localparam logic [6:0] KIND_BANG_EQ = 7'd50;
   localparam logic [6:0] KIND_ASSIGN = 7'd51;
   localparam logic [6:0] KIND_EQ_EQ = 7'd52;
   localparam logic [6:0] KIND_LT = 7'd53;
   localparam logic [6:0] KIND_LT_EQ = 7'd54;
   localparam logic [6:0] KIND_SHL = 7'd55;
   localparam logic [6:0] KIND_SHL_EQ = 7'd56;
   localparam logic [6:0] KIND_GT = 7'd57;
   localparam logic [6:0] KIND_GT_EQ = 7'd58;
   localparam logic [6:0] KIND_SHR = 7'd59;
   localparam logic [6:0] KIND_SHR_EQ = 7'd60;
   localparam logic [6:0] KIND_PIPE = 7'd61;
   localparam logic [6:0] KIND_PIPE_EQ = 7'd62;
   localparam logic [6:0] KIND_AMP = 7'd63;
   localparam logic [6:0] KIND_AMP_EQ = 7'd64;
   localparam logic [6:0] KIND_PERCENT = 7'd65;
   localparam logic [6:0] KIND_TILDE = 7'd66;
   localparam logic [6:0] KIND_CARET = 7'd67;
   localparam logic [6:0] KIND_CARET_EQ = 7'd68;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [2:0] CHECK_X = 3'd2;
   localparam logic [2:0] CHECK_SPACE = 3'd4;
   localparam logic [2:0] PHASE_DIGITS = 3'd7;

   localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
      "and", "assert", "break", "case", "continue", "default", "else", "error",
      "exit", "false", "fn", "for", "if", "let", "nil", "or", "print", "return",
      "self", "super", "switch", "true", "type", "while"
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd3, 4'd6, 4'd5, 4'd4, 4'd8, 4'd7, 4'd4, 4'd5, 4'd4, 4'd5, 4'd2, 4'd3,
      4'd2, 4'd3, 4'd3, 4'd2, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd4, 4'd5
   };

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_COMMENT = 7'b0000010,
      MODE_IDENT   = 7'b0000100,
      MODE_NUMBER  = 7'b0001000,
      MODE_STRING  = 7'b0010000,
      MODE_OP      = 7'b0100000,
      MODE_SHIFT   = 7'b1000000
   } scan_mode_type;

   typedef struct packed {
      logic       shift;
      logic       take;
      logic [6:0] kind;
   } op_result_type;

   typedef struct packed {
      logic       head_valid;
      logic       full;
      logic [2:0] head_count;
   } queue_status_type;

   function automatic logic is_decimal_char(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_decimal_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == " ") || (c == CH_CR) || (c == CH_TAB);
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return (c == "-") || (c == "+") || (c == "/") || (c == "*") || (c == "!") ||
             (c == "=") || (c == "<") || (c == ">") || (c == "|") || (c == "&") ||
             (c == "^");
   endfunction

   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] kind;
      case (c)
         "(": kind = KIND_LPAREN;
         ")": kind = KIND_RPAREN;
         "{": kind = KIND_LBRACE;
         "}": kind = KIND_RBRACE;
         "[": kind = KIND_LBRACKET;
         "]": kind = KIND_RBRACKET;
         ":": kind = KIND_COLON;
         ";": kind = KIND_SEMICOLON;
         ",": kind = KIND_COMMA;
         ".": kind = KIND_DOT;
         default: kind = KIND_END;
      endcase
      return kind;
   endfunction

   // Returns {found, index} of the number continuation byte.
   function automatic logic [3:0] check_index(input logic [7:0] c);
      logic [3:0] res;
      case (c)
         ".": res = {1'b1, 3'd0};
         "_": res = {1'b1, 3'd1};
         "x": res = {1'b1, 3'd2};
         "b": res = {1'b1, 3'd3};
         " ": res = {1'b1, 3'd4};
         "o": res = {1'b1, 3'd5};
         default: res = 4'd0;
      endcase
      return res;
   endfunction

   function automatic op_result_type op_close(input logic [7:0] op, input logic [7:0] c);
      op_result_type r;
      r.shift = 1'b0;
      r.take = 1'b1;
      r.kind = KIND_CARET;
      case (op)
         "-": begin
            if (c == "=") r.kind = KIND_MINUS_EQ;
            else if (c == "-") r.kind = KIND_DEC;
            else begin r.kind = KIND_MINUS; r.take = 1'b0; end
         end
         "+": begin
            if (c == "=") r.kind = KIND_PLUS_EQ;
            else if (c == "+") r.kind = KIND_INC;
            else begin r.kind = KIND_PLUS; r.take = 1'b0; end
         end
         "/": begin
            if (c == "=") r.kind = KIND_SLASH_EQ;
            else begin r.kind = KIND_SLASH; r.take = 1'b0; end
         end
         "*": begin
            if (c == "=") r.kind = KIND_STAR_EQ;
            else begin r.kind = KIND_STAR; r.take = 1'b0; end
         end
         "!": begin
            if (c == "=") r.kind = KIND_BANG_EQ;
            else begin r.kind = KIND_BANG; r.take = 1'b0; end
         end
         "=": begin
            if (c == "=") r.kind = KIND_EQ_EQ;
            else begin r.kind = KIND_ASSIGN; r.take = 1'b0; end
         end
         "<": begin
            if (c == "<") r.shift = 1'b1;
            else if (c == "=") r.kind = KIND_LT_EQ;
            else begin r.kind = KIND_LT; r.take = 1'b0; end
         end
         ">": begin
            if (c == ">") r.shift = 1'b1;
            else if (c == "=") r.kind = KIND_GT_EQ;
            else begin r.kind = KIND_GT; r.take = 1'b0; end
         end
         "|": begin
            if (c == "|") r.kind = KIND_KW_OR;
            else if (c == "=") r.kind = KIND_PIPE_EQ;
            else begin r.kind = KIND_PIPE; r.take = 1'b0; end
         end
         "&": begin
            if (c == "&") r.kind = KIND_KW_AND;
            else if (c == "=") r.kind = KIND_AMP_EQ;
            else begin r.kind = KIND_AMP; r.take = 1'b0; end
         end
         default: begin
            if (c == "=") r.kind = KIND_CARET_EQ;
            else begin r.kind = KIND_CARET; r.take = 1'b0; end
         end
      endcase
      return r;
   endfunction

   // Word prefix holds character i at bits [i*8 +: 8]; len saturates at 9.
   function automatic logic [6:0] keyword_kind(input logic [KEYWORD_CHARS*8-1:0] pfx,
                                               input logic [3:0] len);
      logic [KEYWORD_CHARS*8-1:0] word;
      logic [6:0] kind;
      word = '0;
      kind = KIND_IDENT;
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         if (4'(i) < len) word = {word[KEYWORD_CHARS*8-9:0], pfx[i*8 +: 8]};
      end
      if ((len >= 4'd1) && (len <= 4'(KEYWORD_CHARS))) begin
         for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if ((KW_LEN[k] == len) && (KW_TEXT[k] == word)) kind = KIND_KW_FIRST + 7'(k);
         end
      end
      return kind;
   endfunction

endpackage

// File: rtl/sts_front.sv
// Scanner front end: takes one text byte per transfer, updates the scan state
// and builds a batch of up to four tokens. Depends on sts_pkg.
module sts_front
   import sts_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS = 24,
   parameter int LENGTH_BITS = 16,
   localparam int REC_BITS = 9 + OFFSET_BITS + LENGTH_BITS + LINE_BITS,
   localparam int BATCH_BITS = 3 + MAX_TOKENS * REC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            text_byte,
   output logic                  batch_push,
   output logic [BATCH_BITS-1:0] batch_data
);

   localparam int SCAN_STEPS = 10;

   scan_mode_type mode_ff, mode_in;
   logic [2:0] phase_ff, phase_in;
   logic hex_ff, hex_in;
   logic pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [LENGTH_BITS-1:0] run_ff, run_in;
   logic [KEYWORD_CHARS*8-1:0] prefix_ff, prefix_in;

   scan_mode_type m;
   logic [2:0] ph, p;
   logic hx;
   logic [7:0] la0, la1, c, d;
   logic [1:0] cnt, pos_d, nl_d, rl_d, ts_d;
   logic rl_rst, ts_new, stop, clr, d_ok, take, em, em_zero, ok;
   logic [6:0] em_kind, sk;
   logic [1:0] em_code;
   logic [KEYWORD_CHARS*8-1:0] pfx;
   logic [2:0] n;
   logic [3:0] rl_small, rl_sum, rl_eff, chk;
   op_result_type opr;

   logic [6:0] e_kind [MAX_TOKENS];
   logic [1:0] e_code [MAX_TOKENS];
   logic e_zero [MAX_TOKENS];
   logic e_tsnew [MAX_TOKENS];
   logic [1:0] e_tsd [MAX_TOKENS];
   logic e_rlrst [MAX_TOKENS];
   logic [1:0] e_rld [MAX_TOKENS];
   logic [1:0] e_nl [MAX_TOKENS];

   function automatic logic [OFFSET_BITS-1:0] sat_pos(input logic [OFFSET_BITS-1:0] x,
                                                      input logic [1:0] dl);
      logic [OFFSET_BITS:0] s;
      s = {1'b0, x} + {{(OFFSET_BITS-1){1'b0}}, dl};
      return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] x,
                                                     input logic [1:0] dl);
      logic [LINE_BITS:0] s;
      s = {1'b0, x} + {{(LINE_BITS-1){1'b0}}, dl};
      return s[LINE_BITS] ? {LINE_BITS{1'b1}} : s[LINE_BITS-1:0];
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] x,
                                                      input logic [1:0] dl);
      logic [LENGTH_BITS:0] s;
      s = {1'b0, x} + {{(LENGTH_BITS-1){1'b0}}, dl};
      return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
   endfunction

   always_comb begin
      m = mode_ff;
      ph = phase_ff;
      hx = hex_ff;
      pfx = prefix_ff;
      la0 = pend_valid_ff ? pend_byte_ff : text_byte;
      la1 = text_byte;
      cnt = pend_valid_ff ? 2'd2 : 2'd1;
      pos_d = 2'd0;
      nl_d = 2'd0;
      rl_d = 2'd0;
      ts_d = 2'd0;
      rl_rst = 1'b0;
      ts_new = 1'b0;
      stop = 1'b0;
      clr = 1'b0;
      n = 3'd0;
      c = 8'd0;
      d = 8'd0;
      d_ok = 1'b0;
      take = 1'b0;
      em = 1'b0;
      em_zero = 1'b0;
      em_kind = KIND_END;
      em_code = ERR_NONE;
      ok = 1'b0;
      p = 3'd0;
      sk = KIND_END;
      chk = 4'd0;
      opr = '0;
      rl_small = (run_ff > LENGTH_BITS'(9)) ? 4'd9 : run_ff[3:0];
      rl_sum = 4'd0;
      rl_eff = 4'd0;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         e_kind[i] = KIND_END;
         e_code[i] = ERR_NONE;
         e_zero[i] = 1'b0;
         e_tsnew[i] = 1'b0;
         e_tsd[i] = 2'd0;
         e_rlrst[i] = 1'b0;
         e_rld[i] = 2'd0;
         e_nl[i] = 2'd0;
      end
      for (int it = 0; it < SCAN_STEPS; it++) begin
         if (!stop) begin
            take = 1'b0;
            em = 1'b0;
            em_zero = 1'b0;
            em_kind = KIND_END;
            em_code = ERR_NONE;
            if (cnt == 2'd0) begin
               stop = 1'b1;
            end else begin
               c = la0;
               d_ok = (la0 == CH_NUL) || (cnt == 2'd2);
               d = (la0 == CH_NUL) ? CH_NUL : la1;
               rl_sum = rl_small + {2'b00, rl_d};
               rl_eff = rl_rst ? {2'b00, rl_d} : ((rl_sum > 4'd9) ? 4'd9 : rl_sum);
               case (m)
                  MODE_IDLE: begin
                     if (is_blank(c)) begin
                        take = 1'b1;
                     end else if (c == CH_NL) begin
                        nl_d = nl_d + 2'd1;
                        take = 1'b1;
                     end else if (c == "#") begin
                        m = MODE_COMMENT;
                     end else if (c == CH_NUL) begin
                        ts_new = 1'b1;
                        ts_d = pos_d;
                        em = 1'b1;
                        em_zero = 1'b1;
                        em_kind = KIND_END;
                        clr = 1'b1;
                        stop = 1'b1;
                     end else if ((c == "/") && !d_ok) begin
                        stop = 1'b1;
                     end else if ((c == "/") && (d == "/")) begin
                        m = MODE_COMMENT;
                     end else begin
                        ts_new = 1'b1;
                        ts_d = pos_d;
                        rl_rst = 1'b1;
                        rl_d = 2'd0;
                        take = 1'b1;
                        sk = single_kind(c);
                        if (is_word_char(c)) begin
                           pfx[7:0] = c;
                           m = MODE_IDENT;
                        end else if (is_decimal_char(c)) begin
                           ph = 3'd0;
                           hx = 1'b0;
                           m = MODE_NUMBER;
                        end else if (sk != KIND_END) begin
                           em = 1'b1;
                           em_kind = sk;
                        end else if (c == "\"") begin
                           m = MODE_STRING;
                        end else if (c == "%") begin
                           em = 1'b1;
                           em_kind = KIND_PERCENT;
                        end else if (c == "~") begin
                           em = 1'b1;
                           em_kind = KIND_TILDE;
                        end else if (is_op_start(c)) begin
                           pfx[7:0] = c;
                           m = MODE_OP;
                        end else begin
                           em = 1'b1;
                           em_kind = KIND_ERROR;
                           em_code = ERR_UNEXPECTED;
                           em_zero = 1'b1;
                        end
                     end
                  end
                  MODE_COMMENT: begin
                     if ((c == CH_NL) || (c == CH_NUL)) m = MODE_IDLE;
                     else take = 1'b1;
                  end
                  MODE_IDENT: begin
                     if (is_word_char(c) || is_decimal_char(c)) begin
                        if (rl_eff < 4'(KEYWORD_CHARS)) pfx[rl_eff[2:0]*8 +: 8] = c;
                        take = 1'b1;
                     end else begin
                        em = 1'b1;
                        em_kind = keyword_kind(pfx, rl_eff);
                     end
                  end
                  MODE_STRING: begin
                     if (c == CH_NUL) begin
                        em = 1'b1;
                        em_kind = KIND_ERROR;
                        em_code = ERR_UNTERMINATED;
                        em_zero = 1'b1;
                     end else begin
                        if (c == CH_NL) nl_d = nl_d + 2'd1;
                        take = 1'b1;
                        if (c == "\"") begin
                           em = 1'b1;
                           em_kind = KIND_STRING;
                        end
                     end
                  end
                  MODE_NUMBER: begin
                     if ((ph == 3'd0) && is_decimal_char(c)) begin
                        take = 1'b1;
                     end else begin
                        p = (ph == 3'd0) ? 3'd1 : ph;
                        if (p < PHASE_DIGITS) begin
                           chk = check_index(c);
                           if (chk[3] && (chk[2:0] >= (p - 3'd1))) begin
                              if (!d_ok) begin
                                 ph = chk[2:0] + 3'd1;
                                 stop = 1'b1;
                              end else begin
                                 ok = ((chk[2:0] == CHECK_X) || (chk[2:0] == CHECK_SPACE)) ?
                                      is_hex(d) : is_decimal_char(d);
                                 if (ok) begin
                                    take = 1'b1;
                                    if (chk[2:0] == CHECK_X) hx = 1'b1;
                                 end
                                 ph = chk[2:0] + 3'd2;
                              end
                           end else begin
                              ph = PHASE_DIGITS;
                           end
                        end else if ((hx ? is_hex(c) : is_decimal_char(c)) || (c == "_") ||
                                     (c == " ")) begin
                           take = 1'b1;
                        end else begin
                           em = 1'b1;
                           em_kind = KIND_NUMBER;
                        end
                     end
                  end
                  MODE_OP: begin
                     opr = op_close(pfx[7:0], c);
                     if (opr.shift) begin
                        take = 1'b1;
                        m = MODE_SHIFT;
                     end else begin
                        take = opr.take;
                        em = 1'b1;
                        em_kind = opr.kind;
                     end
                  end
                  MODE_SHIFT: begin
                     em = 1'b1;
                     if (c == "=") begin
                        take = 1'b1;
                        em_kind = (pfx[7:0] == "<") ? KIND_SHL_EQ : KIND_SHR_EQ;
                     end else begin
                        em_kind = (pfx[7:0] == "<") ? KIND_SHL : KIND_SHR;
                     end
                  end
                  default: begin
                     m = MODE_IDLE;
                  end
               endcase
               if (take) begin
                  la0 = la1;
                  cnt = cnt - 2'd1;
                  pos_d = pos_d + 2'd1;
                  rl_d = rl_d + 2'd1;
               end
               if (em) begin
                  if (n < 3'(MAX_TOKENS)) begin
                     e_kind[n[1:0]] = em_kind;
                     e_code[n[1:0]] = em_code;
                     e_zero[n[1:0]] = em_zero;
                     e_tsnew[n[1:0]] = ts_new;
                     e_tsd[n[1:0]] = ts_d;
                     e_rlrst[n[1:0]] = rl_rst;
                     e_rld[n[1:0]] = rl_d;
                     e_nl[n[1:0]] = nl_d;
                     n = n + 3'd1;
                  end
                  m = MODE_IDLE;
               end
            end
         end
      end
   end

   always_comb begin
      batch_data = '0;
      batch_data[BATCH_BITS-1 -: 3] = n;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         batch_data[i*REC_BITS +: OFFSET_BITS] =
            e_tsnew[i] ? sat_pos(pos_ff, e_tsd[i]) : start_ff;
         batch_data[i*REC_BITS + OFFSET_BITS +: LENGTH_BITS] =
            e_zero[i] ? '0 :
            (e_rlrst[i] ? {{(LENGTH_BITS-2){1'b0}}, e_rld[i]} : sat_len(run_ff, e_rld[i]));
         batch_data[i*REC_BITS + OFFSET_BITS + LENGTH_BITS +: LINE_BITS] =
            sat_line(line_ff, e_nl[i]);
         batch_data[i*REC_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS +: 2] = e_code[i];
         batch_data[i*REC_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS + 2 +: 7] = e_kind[i];
      end
      batch_push = step_en && (n != 3'd0);
   end

   always_comb begin
      mode_in = mode_ff;
      phase_in = phase_ff;
      hex_in = hex_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in = pend_byte_ff;
      start_in = start_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      run_in = run_ff;
      prefix_in = prefix_ff;
      if (step_en) begin
         prefix_in = pfx;
         pend_byte_in = la0;
         if (clr) begin
            mode_in = MODE_IDLE;
            phase_in = 3'd0;
            hex_in = 1'b0;
            pend_valid_in = 1'b0;
            start_in = '0;
            pos_in = '0;
            line_in = {{(LINE_BITS-1){1'b0}}, 1'b1};
            run_in = '0;
         end else begin
            mode_in = m;
            phase_in = ph;
            hex_in = hx;
            pend_valid_in = (cnt != 2'd0);
            start_in = ts_new ? sat_pos(pos_ff, ts_d) : start_ff;
            pos_in = sat_pos(pos_ff, pos_d);
            line_in = sat_line(line_ff, nl_d);
            run_in = rl_rst ? {{(LENGTH_BITS-2){1'b0}}, rl_d} : sat_len(run_ff, rl_d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         phase_ff <= 3'd0;
         hex_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         start_ff <= '0;
         pos_ff <= '0;
         line_ff <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         run_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         phase_ff <= phase_in;
         hex_ff <= hex_in;
         pend_valid_ff <= pend_valid_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      prefix_ff <= prefix_in;
   end

endmodule

// File: rtl/sts_queue.sv
// Two-entry token batch queue between the scanner front end and the output
// stage. Depends on sts_pkg.
module sts_queue
   import sts_pkg::*;
#(
   parameter int BATCH_BITS = 327
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [BATCH_BITS-1:0] push_data,
   input  logic                  pop,
   output logic [BATCH_BITS-1:0] head_data,
   output queue_status_type      status
);

   logic [BATCH_BITS-1:0] entry_ff [2];
   logic [BATCH_BITS-1:0] entry_in [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      entry_in = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) rd_ptr_in = ~rd_ptr_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign status.head_valid = (count_ff != 2'd0);
   assign status.full = (count_ff == 2'd2);
   assign status.head_count = head_data[BATCH_BITS-1 -: 3];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/sts_back.sv
// Output stage: presents the tokens of the head batch one per transfer and
// marks the last one. Depends on sts_pkg.
module sts_back
   import sts_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS = 24,
   parameter int LENGTH_BITS = 16,
   localparam int REC_BITS = 9 + OFFSET_BITS + LENGTH_BITS + LINE_BITS,
   localparam int BATCH_BITS = 3 + MAX_TOKENS * REC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [BATCH_BITS-1:0]  head_data,
   input  queue_status_type       status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [6:0]             rsp_token_kind,
   output logic [OFFSET_BITS-1:0] rsp_start_offset,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic [LINE_BITS-1:0]   rsp_line_number,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last_of_run
);

   logic [1:0] sub_ff, sub_in;
   logic [REC_BITS-1:0] rec;
   logic xfer;

   assign rec = head_data[sub_ff*REC_BITS +: REC_BITS];
   assign rsp_valid = status.head_valid;
   assign rsp_start_offset = rec[OFFSET_BITS-1:0];
   assign rsp_token_length = rec[OFFSET_BITS +: LENGTH_BITS];
   assign rsp_line_number = rec[OFFSET_BITS + LENGTH_BITS +: LINE_BITS];
   assign rsp_error_code = rec[OFFSET_BITS + LENGTH_BITS + LINE_BITS +: 2];
   assign rsp_token_kind = rec[OFFSET_BITS + LENGTH_BITS + LINE_BITS + 2 +: 7];
   assign rsp_last_of_run = ({1'b0, sub_ff} == (status.head_count - 3'd1));
   assign xfer = rsp_valid && rsp_ready;
   assign pop = xfer && rsp_last_of_run;

   always_comb begin
      sub_in = sub_ff;
      if (xfer) sub_in = rsp_last_of_run ? 2'd0 : sub_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

// File: rtl/script_token_scanner.sv
// Script token scanner top level: front end, batch queue and output stage.
// Takes one text byte per cycle while the two-entry batch queue has room; the
// tokens caused by a byte are written into the queue as one batch and, after any
// earlier batches, appear on the result side one per cycle while rsp_ready is high.
// Synchronous reset empties the queue and sets offset 0 and line 1.
// Depends on sts_pkg, sts_front, sts_queue, sts_back and the defines header.
`include "script_token_scanner_defines.svh"

module script_token_scanner
   import sts_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_text_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [6:0]             rsp_token_kind,
   output logic [OFFSET_BITS-1:0] rsp_start_offset,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic [LINE_BITS-1:0]   rsp_line_number,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last_of_run
);

   localparam int REC_BITS = 9 + OFFSET_BITS + LENGTH_BITS + LINE_BITS;
   localparam int BATCH_BITS = 3 + MAX_TOKENS * REC_BITS;

   logic step_en;
   logic batch_push;
   logic [BATCH_BITS-1:0] batch_data;
   logic [BATCH_BITS-1:0] head_data;
   logic pop;
   queue_status_type q_status;

   assign req_ready = !q_status.full;
   assign step_en = req_valid && req_ready;

   sts_front #(
      .OFFSET_BITS(OFFSET_BITS),
      .LINE_BITS(LINE_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .text_byte(req_text_byte),
      .batch_push(batch_push),
      .batch_data(batch_data)
   );

   sts_queue #(
      .BATCH_BITS(BATCH_BITS)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(batch_push),
      .push_data(batch_data),
      .pop(pop),
      .head_data(head_data),
      .status(q_status)
   );

   sts_back #(
      .OFFSET_BITS(OFFSET_BITS),
      .LINE_BITS(LINE_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_data(head_data),
      .status(q_status),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_token_kind(rsp_token_kind),
      .rsp_start_offset(rsp_start_offset),
      .rsp_token_length(rsp_token_length),
      .rsp_line_number(rsp_line_number),
      .rsp_error_code(rsp_error_code),
      .rsp_last_of_run(rsp_last_of_run)
   );

   `STS_ASSERT_AT_CLOCK(a_end_byte_emits, (step_en && (req_text_byte == CH_NUL)) |-> batch_push, "end of text produced no tokens")
   `STS_ASSERT_AT_CLOCK(a_head_not_empty, rsp_valid |-> (q_status.head_count != 3'd0), "queued batch holds no tokens")
   `STS_ASSERT_AT_CLOCK(a_end_is_last, (rsp_valid && (rsp_token_kind == KIND_END)) |-> rsp_last_of_run, "end token is not last of its batch")
   `STS_ASSERT_NEVER(a_no_overflow, batch_push && q_status.full, "batch written into a full queue")

endmodule
